// ===== rtl/core/ofan_pkg.sv =====
`timescale 1ns / 1ps

package ofan_pkg;

	localparam int INDEX_BITS = 24;
	localparam int CORNER_W   = INDEX_BITS + 1;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_HASH    = 8'h23;
	localparam logic [7:0] CHAR_PLUS    = 8'h2b;
	localparam logic [7:0] CHAR_MINUS   = 8'h2d;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_FACE    = 8'h66;

	typedef enum logic [1:0] {
		SLOT_APEX,
		SLOT_MIDDLE,
		SLOT_FIRST_TRI,
		SLOT_FAN
	} slot_t;

	typedef struct packed {
		slot_t                       slot;
		logic signed [CORNER_W-1:0]  value;
	} token_t;

endpackage

// ===== rtl/core/ofan_front.sv =====
`timescale 1ns / 1ps

module ofan_front import ofan_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_take,
	input  logic [7:0]  file_byte,
	input  logic        end_of_file,
	output logic        tok_push,
	output token_t      tok_word
);

	typedef enum logic [1:0] {
		COL_FIRST,
		COL_SECOND,
		COL_BODY
	} col_t;

	col_t                   col_q, col_d;
	logic                   face_q, face_d;
	logic                   stop_q, stop_d;
	logic                   psp_q, psp_d;
	logic                   innum_q, innum_d;
	logic                   neg_q, neg_d;
	logic                   hasd_q, hasd_d;
	logic [INDEX_BITS-1:0]  mag_q, mag_d;
	slot_t                  cs_q, cs_d;

	logic                   tok_valid;
	token_t                 tok_d;
	logic                   is_digit;
	logic [INDEX_BITS+3:0]  mag_ext;
	logic [INDEX_BITS+3:0]  mag_prod;
	logic [INDEX_BITS-1:0]  mag_next;

	function automatic logic signed [CORNER_W-1:0] index_value(
		input logic                  ok,
		input logic                  neg,
		input logic [INDEX_BITS-1:0] mag
	);
		logic signed [CORNER_W-1:0] v;
		if (!ok) begin
			v = '1;
		end else if (neg) begin
			v = {1'b1, ~mag};
		end else begin
			v = {1'b0, mag} - {{INDEX_BITS{1'b0}}, 1'b1};
		end
		return v;
	endfunction

	assign is_digit = (file_byte >= CHAR_ZERO) && (file_byte <= CHAR_NINE);
	assign mag_ext  = {4'b0, mag_q};
	assign mag_prod = (mag_ext << 3) + (mag_ext << 1) + {{INDEX_BITS{1'b0}}, file_byte[3:0]};
	assign mag_next = (mag_prod[INDEX_BITS+3:INDEX_BITS] != 4'b0) ? '1
		: mag_prod[INDEX_BITS-1:0];

	always_comb begin
		col_d     = col_q;
		face_d    = face_q;
		stop_d    = stop_q;
		psp_d     = psp_q;
		innum_d   = innum_q;
		neg_d     = neg_q;
		hasd_d    = hasd_q;
		mag_d     = mag_q;
		cs_d      = cs_q;
		tok_valid = 1'b0;
		tok_d     = '{slot: SLOT_APEX, value: '0};

		if (file_byte == CHAR_NEWLINE) begin
			if (face_d && !stop_d && innum_d) begin
				tok_valid   = 1'b1;
				tok_d.value = index_value(hasd_d, neg_d, mag_d);
				tok_d.slot  = cs_d;
			end
		end else begin
			unique case (col_q)
				COL_FIRST: begin
					face_d = (file_byte == CHAR_FACE);
					col_d  = COL_SECOND;
				end
				COL_SECOND: begin
					face_d = face_q && (file_byte == CHAR_SPACE);
					psp_d  = 1'b1;
					cs_d   = SLOT_APEX;
					col_d  = COL_BODY;
				end
				default: begin
					if (face_q && !stop_q) begin
						if (innum_q) begin
							if (is_digit) begin
								mag_d  = mag_next;
								hasd_d = 1'b1;
							end else begin
								tok_valid   = 1'b1;
								tok_d.value = index_value(hasd_q, neg_q, mag_q);
								tok_d.slot  = cs_q;
								innum_d     = 1'b0;
								neg_d       = 1'b0;
								hasd_d      = 1'b0;
								mag_d       = '0;
								if (!hasd_q) begin
									stop_d = 1'b1;
								end else begin
									if (file_byte == CHAR_HASH) begin
										stop_d = 1'b1;
									end
									psp_d = (file_byte == CHAR_SPACE);
								end
							end
						end else if (file_byte == CHAR_HASH) begin
							stop_d = 1'b1;
						end else if (psp_q && file_byte != CHAR_SPACE) begin
							if (is_digit) begin
								innum_d = 1'b1;
								neg_d   = 1'b0;
								mag_d   = {{(INDEX_BITS-4){1'b0}}, file_byte[3:0]};
								hasd_d  = 1'b1;
							end else if (file_byte == CHAR_PLUS || file_byte == CHAR_MINUS) begin
								innum_d = 1'b1;
								neg_d   = (file_byte == CHAR_MINUS);
								hasd_d  = 1'b0;
								mag_d   = '0;
							end else begin
								tok_valid   = 1'b1;
								tok_d.value = index_value(1'b0, neg_q, mag_q);
								tok_d.slot  = cs_q;
								innum_d     = 1'b0;
								neg_d       = 1'b0;
								hasd_d      = 1'b0;
								mag_d       = '0;
								stop_d      = 1'b1;
							end
						end else begin
							psp_d = (file_byte == CHAR_SPACE);
						end
					end
				end
			endcase

			if (end_of_file && !tok_valid && face_d && col_d == COL_BODY && !stop_d
				&& innum_d) begin
				tok_valid   = 1'b1;
				tok_d.value = index_value(hasd_d, neg_d, mag_d);
				tok_d.slot  = cs_d;
			end
		end

		if (tok_valid) begin
			cs_d = (cs_d == SLOT_FAN) ? SLOT_FAN : slot_t'(cs_d + 2'd1);
		end

		if (file_byte == CHAR_NEWLINE || end_of_file) begin
			col_d   = COL_FIRST;
			face_d  = 1'b0;
			stop_d  = 1'b0;
			psp_d   = 1'b1;
			innum_d = 1'b0;
			neg_d   = 1'b0;
			hasd_d  = 1'b0;
			mag_d   = '0;
			cs_d    = SLOT_APEX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= COL_FIRST;
			face_q  <= 1'b0;
			stop_q  <= 1'b0;
			psp_q   <= 1'b1;
			innum_q <= 1'b0;
			neg_q   <= 1'b0;
			hasd_q  <= 1'b0;
			mag_q   <= '0;
			cs_q    <= SLOT_APEX;
		end else if (byte_take) begin
			col_q   <= col_d;
			face_q  <= face_d;
			stop_q  <= stop_d;
			psp_q   <= psp_d;
			innum_q <= innum_d;
			neg_q   <= neg_d;
			hasd_q  <= hasd_d;
			mag_q   <= mag_d;
			cs_q    <= cs_d;
		end
	end

	assign tok_push = byte_take && tok_valid;
	assign tok_word = tok_d;

`ifndef SYNTHESIS
	a_push_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		tok_push |-> (col_q == COL_BODY))
		else $error("index word pushed outside the body of a line");

	a_digit_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(mag_q != '0) |-> (innum_q && hasd_q))
		else $error("magnitude held without a number in progress");
`endif

endmodule

// ===== rtl/core/ofan_fifo.sv =====
`timescale 1ns / 1ps

module ofan_fifo import ofan_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  token_t push_word,
	input  logic   pop,
	output logic   full,
	output logic   empty,
	output token_t head_word
);

	token_t      mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full      = (count_q == 2'd2);
	assign empty     = (count_q == 2'd0);
	assign head_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");
`endif

endmodule

// ===== rtl/core/ofan_back.sv =====
`timescale 1ns / 1ps

module ofan_back import ofan_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        tok_empty,
	input  token_t                      tok_word,
	output logic                        tok_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [CORNER_W-1:0]  corner_a,
	output logic signed [CORNER_W-1:0]  corner_b,
	output logic signed [CORNER_W-1:0]  corner_c
);

	logic signed [CORNER_W-1:0] apex_q;
	logic signed [CORNER_W-1:0] middle_q;
	logic signed [CORNER_W-1:0] newest_q;
	logic signed [CORNER_W-1:0] out_a_q;
	logic signed [CORNER_W-1:0] out_b_q;
	logic signed [CORNER_W-1:0] out_c_q;
	logic                       out_valid_q;
	logic                       emits;

	assign tok_pop = !tok_empty && (!out_valid_q || out_ready);
	assign emits   = (tok_word.slot == SLOT_FIRST_TRI) || (tok_word.slot == SLOT_FAN);

	always_ff @(posedge clk) begin
		if (tok_pop) begin
			unique case (tok_word.slot)
				SLOT_APEX: begin
					apex_q <= tok_word.value;
				end
				SLOT_MIDDLE: begin
					middle_q <= tok_word.value;
				end
				SLOT_FIRST_TRI: begin
					newest_q <= tok_word.value;
					out_a_q  <= apex_q;
					out_b_q  <= middle_q;
					out_c_q  <= tok_word.value;
				end
				default: begin
					middle_q <= newest_q;
					newest_q <= tok_word.value;
					out_a_q  <= apex_q;
					out_b_q  <= newest_q;
					out_c_q  <= tok_word.value;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tok_pop) begin
			out_valid_q <= emits;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign corner_a  = out_a_q;
	assign corner_b  = out_b_q;
	assign corner_c  = out_c_q;

`ifndef SYNTHESIS
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_pop && emits) |=> out_valid_q)
		else $error("triangle word popped but not presented");
`endif

endmodule

// ===== rtl/core/obj_face_fan_triangulator.sv =====
// A triangle's last index is queued, then popped into the registered corner outputs.
// Throughput: one byte per cycle while the queue is not full; one triangle word per cycle at most.
// The front parser and the triangle stage are split by a two-word queue, so either side
// stalls on its own; bytes are refused only while that queue is full.
// Reset: arst_n is asynchronous, active low, and clears all parser and handshake state.
`timescale 1ns / 1ps

module obj_face_fan_triangulator import ofan_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  file_byte,
	input  logic                        end_of_file,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [CORNER_W-1:0]  corner_a,
	output logic signed [CORNER_W-1:0]  corner_b,
	output logic signed [CORNER_W-1:0]  corner_c
);

	logic   byte_take;
	logic   tok_push;
	token_t tok_in;
	logic   tok_pop;
	logic   tok_full;
	logic   tok_empty;
	token_t tok_head;

	assign in_ready  = !tok_full;
	assign byte_take = in_valid && in_ready;

	ofan_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_take   (byte_take),
		.file_byte   (file_byte),
		.end_of_file (end_of_file),
		.tok_push    (tok_push),
		.tok_word    (tok_in)
	);

	ofan_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (tok_push),
		.push_word (tok_in),
		.pop       (tok_pop),
		.full      (tok_full),
		.empty     (tok_empty),
		.head_word (tok_head)
	);

	ofan_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_empty (tok_empty),
		.tok_word  (tok_head),
		.tok_pop   (tok_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.corner_a  (corner_a),
		.corner_b  (corner_b),
		.corner_c  (corner_c)
	);

endmodule
